// ===== hw/rtl/rmre_pkg.sv =====
// shared types and constants for the mask row run-length encoder
// no dependencies; every other rtl file imports this package
`default_nettype none

package rmre_pkg;

    localparam int PIX_W        = 32;
    localparam int COUNT_W      = 6;
    localparam int OFFSET_W     = 11;
    localparam int BYTES_W      = 12;
    localparam int BLOCK_SIDE_D = 32;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_TOTAL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_RUN,
        PH_TOTAL
    } t_phase;

    // result of scanning one row for pixel changes
    typedef struct packed {
        logic [PIX_W-1:0]   mask;
        logic [COUNT_W-1:0] nruns;
        logic               first_inv;
    } t_scan;

    // everything the emitter needs to produce one row's results
    typedef struct packed {
        logic [PIX_W-1:0]    mask;
        logic [COUNT_W-1:0]  nruns;
        logic                first_inv;
        logic [OFFSET_W-1:0] offset;
        logic [BYTES_W-1:0]  total;
        logic                final_row;
    } t_row_info;

endpackage

`default_nettype wire

// ===== hw/rtl/rmre_if.sv =====
// valid/ready channel interfaces for mask rows in and encoded results out
// depends on rmre_pkg
`default_nettype none

interface rmre_in_if;
    import rmre_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] row_pixels;

    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

interface rmre_out_if;
    import rmre_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [COUNT_W-1:0]  count;
    logic                first_invisible;
    logic [OFFSET_W-1:0] row_offset_words;
    logic [BYTES_W-1:0]  block_bytes;
    logic                last;

    modport source (output valid, output kind, output count, output first_invisible,
                    output row_offset_words, output block_bytes, output last,
                    input ready);
    modport sink   (input valid, input kind, input count, input first_invisible,
                    input row_offset_words, input block_bytes, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mask_row_run_length_encoder_unit.sv =====
// mask row run-length encoder: one 32-pixel row in, header + runs (+ block total) out
// the row is registered on acceptance, then loaded into the emitter when it is free;
// the emitter registers one result per cycle at its output unless the output stalls;
// a row gives a header, 1 to BLOCK_SIDE runs, and on a block's last row a byte total
// reset clears the row counter and loads the offset and byte counters; no clearing pass
`default_nettype none

module mask_row_run_length_encoder_unit #(
    parameter int BLOCK_SIDE = rmre_pkg::BLOCK_SIDE_D
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmre_in_if.sink     i_row,
    rmre_out_if.source  o_res
);
    import rmre_pkg::*;

    localparam int                  RowW     = $clog2(BLOCK_SIDE);
    localparam logic [OFFSET_W-1:0] OffReset = OFFSET_W'(8 + 2 * BLOCK_SIDE);
    localparam logic [BYTES_W-1:0]  ByteReset = BYTES_W'(16 + 4 * BLOCK_SIDE);

    logic                r_in_valid;
    logic [PIX_W-1:0]    r_pix;
    logic [RowW-1:0]     r_row;
    logic [OFFSET_W-1:0] r_off_acc, n_off_acc;
    logic [BYTES_W-1:0]  r_byte_acc, n_byte_acc;

    t_scan     scan;
    t_row_info info;
    logic      emit_free;
    logic      load;
    logic      final_row;

    assign i_row.ready = !r_in_valid;
    assign load        = r_in_valid && emit_free;

    rmre_row_scan #(.BLOCK_SIDE(BLOCK_SIDE)) u_scan (
        .i_pixels (r_pix),
        .o_scan   (scan)
    );

    assign final_row  = (r_row == RowW'(BLOCK_SIDE - 1));
    assign n_off_acc  = r_off_acc + OFFSET_W'(2) + OFFSET_W'(scan.nruns);
    assign n_byte_acc = r_byte_acc + BYTES_W'(4) + (BYTES_W'(scan.nruns) << 1);

    assign info.mask      = scan.mask;
    assign info.nruns     = scan.nruns;
    assign info.first_inv = scan.first_inv;
    assign info.offset    = r_off_acc;
    assign info.total     = n_byte_acc;
    assign info.final_row = final_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_row      <= '0;
            r_off_acc  <= OffReset;
            r_byte_acc <= ByteReset;
        end else begin
            if (i_row.valid && i_row.ready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                // counters move on as the row enters the emitter
                if (final_row) begin
                    r_row      <= '0;
                    r_off_acc  <= OffReset;
                    r_byte_acc <= ByteReset;
                end else begin
                    r_row      <= r_row + RowW'(1);
                    r_off_acc  <= n_off_acc;
                    r_byte_acc <= n_byte_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row.valid && i_row.ready) begin
            r_pix <= i_row.row_pixels;
        end
    end

    rmre_emitter #(.BLOCK_SIDE(BLOCK_SIDE)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_info  (info),
        .o_free  (emit_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rmre_row_scan.sv =====
// marks pixel changes in one mask row and counts its runs
// depends on rmre_pkg
`default_nettype none

module rmre_row_scan #(
    parameter int BLOCK_SIDE = rmre_pkg::BLOCK_SIDE_D
) (
    input  wire logic [rmre_pkg::PIX_W-1:0] i_pixels,
    output rmre_pkg::t_scan                 o_scan
);
    import rmre_pkg::*;

    logic [PIX_W-1:0] chg;

    // bit w set where pixel w differs from pixel w-1, only inside the row
    always_comb begin
        chg = '0;
        for (int w = 1; w < PIX_W; w++) begin
            if (w < BLOCK_SIDE) begin
                chg[w] = i_pixels[w] ^ i_pixels[w-1];
            end
        end
    end

    assign o_scan.mask      = chg;
    assign o_scan.nruns     = COUNT_W'($countones(chg)) + COUNT_W'(1);
    assign o_scan.first_inv = ~i_pixels[0];

endmodule

`default_nettype wire

// ===== hw/rtl/rmre_emitter.sv =====
// steps through a row's header, run lengths and last-row block total, one result a cycle unless stalled
// depends on rmre_pkg and rmre_out_if
`default_nettype none

module rmre_emitter #(
    parameter int BLOCK_SIDE = rmre_pkg::BLOCK_SIDE_D
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire rmre_pkg::t_row_info i_info,
    output logic                     o_free,
    rmre_out_if.source               o_res
);
    import rmre_pkg::*;

    t_phase              r_phase, n_phase;
    t_row_info           r_info, n_info;
    logic [PIX_W-1:0]    r_mask, n_mask;
    logic [COUNT_W-1:0]  r_pos, n_pos;

    logic                r_out_valid, n_out_valid;
    t_kind               r_kind, n_kind;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_inv, n_inv;
    logic [OFFSET_W-1:0] r_off, n_off;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic                r_last, n_last;

    logic                can_emit;
    logic                finishing;
    logic [COUNT_W-1:0]  nxt_pos;

    assign can_emit = !r_out_valid || o_res.ready;

    // end of the current run: lowest remaining change, or the row end
    always_comb begin
        nxt_pos = COUNT_W'(BLOCK_SIDE);
        for (int i = PIX_W - 1; i >= 1; i--) begin
            if (r_mask[i]) begin
                nxt_pos = COUNT_W'(i);
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_info      = r_info;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_count     = r_count;
        n_inv       = r_inv;
        n_off       = r_off;
        n_bytes     = r_bytes;
        n_last      = r_last;
        finishing   = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_HEADER: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_HEADER;
                    n_count     = r_info.nruns;
                    n_inv       = r_info.first_inv;
                    n_off       = r_info.offset;
                    n_bytes     = '0;
                    n_last      = 1'b0;
                    n_phase     = PH_RUN;
                end
            end
            PH_RUN: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RUN;
                    n_count     = nxt_pos - r_pos;
                    n_inv       = 1'b0;
                    n_off       = '0;
                    n_bytes     = '0;
                    n_last      = 1'b0;
                    n_mask      = r_mask & (r_mask - PIX_W'(1));
                    n_pos       = nxt_pos;
                    if (r_mask == '0) begin
                        if (r_info.final_row) begin
                            n_phase = PH_TOTAL;
                        end else begin
                            n_last    = 1'b1;
                            n_phase   = PH_IDLE;
                            finishing = 1'b1;
                        end
                    end
                end
            end
            PH_TOTAL: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TOTAL;
                    n_count     = '0;
                    n_inv       = 1'b0;
                    n_off       = '0;
                    n_bytes     = r_info.total;
                    n_last      = 1'b1;
                    n_phase     = PH_IDLE;
                    finishing   = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (i_load) begin
            n_phase = PH_HEADER;
            n_info  = i_info;
            n_mask  = i_info.mask;
            n_pos   = '0;
        end
    end

    assign o_free = (r_phase == PH_IDLE) || finishing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_info  <= n_info;
        r_mask  <= n_mask;
        r_pos   <= n_pos;
        r_kind  <= n_kind;
        r_count <= n_count;
        r_inv   <= n_inv;
        r_off   <= n_off;
        r_bytes <= n_bytes;
        r_last  <= n_last;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.kind             = r_kind;
    assign o_res.count            = r_count;
    assign o_res.first_invisible  = r_inv;
    assign o_res.row_offset_words = r_off;
    assign o_res.block_bytes      = r_bytes;
    assign o_res.last             = r_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("row loaded while emitter busy");

    a_header_then_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER && can_emit && !i_load) |=> (r_phase == PH_RUN))
        else $error("header not followed by runs");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_RUN) |-> (r_count != '0))
        else $error("zero-length run emitted");

    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RUN) |-> (r_pos < COUNT_W'(BLOCK_SIDE)))
        else $error("run position past row end");

endmodule

`default_nettype wire
